### sv/dpu_pkg.sv
// Shared constants, register map and field widths for the depth pixel unprojection block.
package dpu_pkg;

    // Pixel coordinate bits that take part in the offset (low bits of column and line)
    localparam int COORD_BITS = 12;

    // Input and output field widths
    localparam int DEPTH_W = 16;
    localparam int COORD_W = 12;
    localparam int COLOR_W = 8;
    localparam int POINT_W = 32;

    // Configuration register widths
    localparam int CENTER_W = 16;
    localparam int INV_F_W  = 24;
    localparam int INV_D_W  = 32;

    // Arithmetic widths
    localparam int MAG_W    = 16;                  // |16*coord - center|
    localparam int PROD_Z_W = DEPTH_W + INV_D_W;   // depth * inv_depth_scale
    localparam int AZ_W     = MAG_W + POINT_W;     // |offset| * z
    localparam int HALF_W   = AZ_W / 2;            // split point of |offset| * z
    localparam int PART_W   = HALF_W + INV_F_W;    // one partial product
    localparam int FULL_W   = AZ_W + INV_F_W;      // full lateral product
    localparam int LAT_SHIFT = 28;
    localparam int LAT_W    = FULL_W - LAT_SHIFT;  // lateral magnitude after shift
    localparam int Z_SHIFT  = 16;

    // APB port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes
    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_INV_FX    = 3'd2;
    localparam logic [2:0] REG_INV_FY    = 3'd3;
    localparam logic [2:0] REG_INV_DEPTH = 3'd4;

    // Reset values
    localparam logic [CENTER_W-1:0] CENTER_X_RST  = 16'd5112;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 16'd3832;
    localparam logic [INV_F_W-1:0]  INV_FX_RST    = 24'd31957;
    localparam logic [INV_F_W-1:0]  INV_FY_RST    = 24'd31957;
    localparam logic [INV_D_W-1:0]  INV_DEPTH_RST = 32'd858993;

    // Stream payload widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 120;

    // Color bytes traveling with a pixel
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

endpackage

### sv/depth_pixel_unprojection.sv
// Top level: pinhole back-projection of RGB-D pixels into Q16.16 points.
//
// Usage:
//   Input stream (s_axis_*) carries one pixel per request: raw depth, column,
//   line and three color bytes. Output stream (m_axis_*) carries one point per
//   request: x, y, z in Q16.16 meters plus the color bytes unchanged. A pixel
//   with zero depth is consumed and produces no point.
//   The APB port holds principal point (Q.4 pixels) and reciprocal focal
//   lengths and depth scale; write it only while no pixel is in flight.
// Timing:
//   Six register stages (s1 to s5, then the output register) lie between a
//   pixel's acceptance and its point. One pixel per cycle is sustained while
//   m_axis_tready is high; the stage count is set by the multiplier chain
//   depth * scale, then |offset| * z, then the 48x24 product in two 24x24 partials.
// Reset:
//   rst_n clears all stage valid bits and loads the default calibration.
// Stall:
//   While m_axis_tready is low and a point waits, the whole pipeline holds,
//   empty stages included, and s_axis_tready drops; nothing is lost or repeated.
module depth_pixel_unprojection
    import dpu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Pixel input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] depth_raw, [27:16] column, [39:28] line,
    // [47:40] blue_in, [55:48] green_in, [63:56] red_in
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Point output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] point_z,
    // [103:96] blue_out, [111:104] green_out, [119:112] red_out
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int CoordUse = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int PosW     = MAG_W + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INV_F_W-1:0]  inv_fx_reg;
    logic [INV_F_W-1:0]  inv_fy_reg;
    logic [INV_D_W-1:0]  inv_depth_reg;
    logic                cfg_write;
    logic [2:0]          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[APB_AW-1:2];

    // Write a register on a completed access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= CENTER_X_RST;
            center_y_reg  <= CENTER_Y_RST;
            inv_fx_reg    <= INV_FX_RST;
            inv_fy_reg    <= INV_FY_RST;
            inv_depth_reg <= INV_DEPTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CENTER_X:  center_x_reg  <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y:  center_y_reg  <= pwdata[CENTER_W-1:0];
                REG_INV_FX:    inv_fx_reg    <= pwdata[INV_F_W-1:0];
                REG_INV_FY:    inv_fy_reg    <= pwdata[INV_F_W-1:0];
                REG_INV_DEPTH: inv_depth_reg <= pwdata[INV_D_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (cfg_index)
            REG_CENTER_X:  prdata = {{(APB_DW-CENTER_W){1'b0}}, center_x_reg};
            REG_CENTER_Y:  prdata = {{(APB_DW-CENTER_W){1'b0}}, center_y_reg};
            REG_INV_FX:    prdata = {{(APB_DW-INV_F_W){1'b0}}, inv_fx_reg};
            REG_INV_FY:    prdata = {{(APB_DW-INV_F_W){1'b0}}, inv_fy_reg};
            REG_INV_DEPTH: prdata = inv_depth_reg;
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline control: all stages advance together
    // ---------------------------------------------------------------
    logic adv;
    logic in_take;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_take       = s_axis_tvalid && adv;

    // ---------------------------------------------------------------
    // Input unpacking
    // ---------------------------------------------------------------
    logic [DEPTH_W-1:0] in_depth;
    logic [COORD_W-1:0] in_column;
    logic [COORD_W-1:0] in_line;
    color_t             in_color;

    assign in_depth       = s_axis_tdata[15:0];
    assign in_column      = s_axis_tdata[27:16];
    assign in_line        = s_axis_tdata[39:28];
    assign in_color.blue  = s_axis_tdata[47:40];
    assign in_color.green = s_axis_tdata[55:48];
    assign in_color.red   = s_axis_tdata[63:56];

    // Signed Q.4 offsets as magnitude and sign
    logic [PosW-1:0]  pos_x, pos_y, diff_x, diff_y;
    logic             neg_x_next, neg_y_next;
    logic [MAG_W-1:0] mag_x_next, mag_y_next;

    assign pos_x      = PosW'({in_column[CoordUse-1:0], 4'b0000});
    assign pos_y      = PosW'({in_line[CoordUse-1:0], 4'b0000});
    assign neg_x_next = pos_x < {1'b0, center_x_reg};
    assign neg_y_next = pos_y < {1'b0, center_y_reg};
    assign diff_x     = neg_x_next ? ({1'b0, center_x_reg} - pos_x)
                                   : (pos_x - {1'b0, center_x_reg});
    assign diff_y     = neg_y_next ? ({1'b0, center_y_reg} - pos_y)
                                   : (pos_y - {1'b0, center_y_reg});
    assign mag_x_next = diff_x[MAG_W-1:0];
    assign mag_y_next = diff_y[MAG_W-1:0];

    // ---------------------------------------------------------------
    // Stage 1: depth times reciprocal scale, offsets
    // ---------------------------------------------------------------
    logic [PROD_Z_W-1:0] s1_prod_reg;
    logic [MAG_W-1:0]    s1_mag_x_reg, s1_mag_y_reg;
    logic                s1_neg_x_reg, s1_neg_y_reg;
    color_t              s1_color_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg  <= PROD_Z_W'(in_depth) * PROD_Z_W'(inv_depth_reg);
            s1_mag_x_reg <= mag_x_next;
            s1_mag_y_reg <= mag_y_next;
            s1_neg_x_reg <= neg_x_next;
            s1_neg_y_reg <= neg_y_next;
            s1_color_reg <= in_color;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: round and saturate z
    // ---------------------------------------------------------------
    logic [PROD_Z_W:0]    z_sum;
    logic [POINT_W-1:0]   z_next;
    logic [POINT_W-1:0]   s2_z_reg;
    logic [MAG_W-1:0]     s2_mag_x_reg, s2_mag_y_reg;
    logic                 s2_neg_x_reg, s2_neg_y_reg;
    color_t               s2_color_reg;

    assign z_sum  = {1'b0, s1_prod_reg} + (PROD_Z_W+1)'(1 << (Z_SHIFT - 1));
    assign z_next = (|z_sum[PROD_Z_W:Z_SHIFT+POINT_W]) ? {POINT_W{1'b1}}
                                                        : z_sum[Z_SHIFT+POINT_W-1:Z_SHIFT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_z_reg     <= z_next;
            s2_mag_x_reg <= s1_mag_x_reg;
            s2_mag_y_reg <= s1_mag_y_reg;
            s2_neg_x_reg <= s1_neg_x_reg;
            s2_neg_y_reg <= s1_neg_y_reg;
            s2_color_reg <= s1_color_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: offset magnitude times z
    // ---------------------------------------------------------------
    logic [AZ_W-1:0]    s3_ax_reg, s3_ay_reg;
    logic [POINT_W-1:0] s3_z_reg;
    logic               s3_neg_x_reg, s3_neg_y_reg;
    color_t             s3_color_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ax_reg    <= AZ_W'(s2_mag_x_reg) * AZ_W'(s2_z_reg);
            s3_ay_reg    <= AZ_W'(s2_mag_y_reg) * AZ_W'(s2_z_reg);
            s3_z_reg     <= s2_z_reg;
            s3_neg_x_reg <= s2_neg_x_reg;
            s3_neg_y_reg <= s2_neg_y_reg;
            s3_color_reg <= s2_color_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: partial products with the reciprocal focal lengths
    // ---------------------------------------------------------------
    logic [PART_W-1:0]  s4_hx_reg, s4_lx_reg, s4_hy_reg, s4_ly_reg;
    logic [POINT_W-1:0] s4_z_reg;
    logic               s4_neg_x_reg, s4_neg_y_reg;
    color_t             s4_color_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_hx_reg    <= PART_W'(s3_ax_reg[AZ_W-1:HALF_W]) * PART_W'(inv_fx_reg);
            s4_lx_reg    <= PART_W'(s3_ax_reg[HALF_W-1:0]) * PART_W'(inv_fx_reg);
            s4_hy_reg    <= PART_W'(s3_ay_reg[AZ_W-1:HALF_W]) * PART_W'(inv_fy_reg);
            s4_ly_reg    <= PART_W'(s3_ay_reg[HALF_W-1:0]) * PART_W'(inv_fy_reg);
            s4_z_reg     <= s3_z_reg;
            s4_neg_x_reg <= s3_neg_x_reg;
            s4_neg_y_reg <= s3_neg_y_reg;
            s4_color_reg <= s3_color_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: combine partials, round half up, shift by 28
    // ---------------------------------------------------------------
    logic [FULL_W-1:0]  full_x, full_y;
    logic [LAT_W-1:0]   s5_rx_reg, s5_ry_reg;
    logic [POINT_W-1:0] s5_z_reg;
    logic               s5_neg_x_reg, s5_neg_y_reg;
    color_t             s5_color_reg;

    assign full_x = {s4_hx_reg, {HALF_W{1'b0}}} + FULL_W'(s4_lx_reg)
                  + FULL_W'(1 << (LAT_SHIFT - 1));
    assign full_y = {s4_hy_reg, {HALF_W{1'b0}}} + FULL_W'(s4_ly_reg)
                  + FULL_W'(1 << (LAT_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_rx_reg    <= full_x[FULL_W-1:LAT_SHIFT];
            s5_ry_reg    <= full_y[FULL_W-1:LAT_SHIFT];
            s5_z_reg     <= s4_z_reg;
            s5_neg_x_reg <= s4_neg_x_reg;
            s5_neg_y_reg <= s4_neg_y_reg;
            s5_color_reg <= s4_color_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: apply sign and saturate into the output register
    // ---------------------------------------------------------------
    logic [POINT_W-1:0] x_next, y_next;
    logic [POINT_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    color_t             out_color_reg;

    function automatic logic [POINT_W-1:0] sat_signed(input logic [LAT_W-1:0] mag,
                                                       input logic            neg);
        logic over;
        over = |mag[LAT_W-1:POINT_W-1];
        if (neg)
            sat_signed = over ? {1'b1, {(POINT_W-1){1'b0}}} : (~mag[POINT_W-1:0] + 1'b1);
        else
            sat_signed = over ? {1'b0, {(POINT_W-1){1'b1}}} : mag[POINT_W-1:0];
    endfunction

    assign x_next = sat_signed(s5_rx_reg, s5_neg_x_reg);
    assign y_next = sat_signed(s5_ry_reg, s5_neg_y_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg     <= x_next;
            out_y_reg     <= y_next;
            out_z_reg     <= s5_z_reg;
            out_color_reg <= s5_color_reg;
        end
    end

    // Advance valid bits; drop pixels with zero depth at entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_take && (in_depth != '0);
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_color_reg.red, out_color_reg.green, out_color_reg.blue,
                            out_z_reg, out_y_reg, out_x_reg};

endmodule

### verif/depth_pixel_unprojection_tb.sv
// Self-checking testbench for the depth pixel unprojection block.
`timescale 1ns / 1ps

module depth_pixel_unprojection_tb
    import dpu_pkg::*;
();

    localparam int PIPE_LATENCY    = 6;
    localparam int SETTLE_CYCLES   = PIPE_LATENCY + 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 10;
    localparam int RAND_PHASES     = 6;
    localparam int PIXELS_PER_PHASE = 165;
    localparam int DIR_ROWS        = 22;
    localparam int DIR_PHASES      = 5;

    // Write to an address past the register map; the block must ignore it
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    // Highest field first so the packed layout matches s_axis_tdata
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COORD_W-1:0] line;
        logic [COORD_W-1:0] column;
        logic [DEPTH_W-1:0] depth;
    } pixel_t;

    // Highest field first so the packed layout matches m_axis_tdata
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [POINT_W-1:0] z;
        logic [POINT_W-1:0] y;
        logic [POINT_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_F_W-1:0]  inv_fx;
        logic [INV_F_W-1:0]  inv_fy;
        logic [INV_D_W-1:0]  inv_depth;
    } calib_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_POINT,
        ROW_LITERAL
    } row_kind_t;

    typedef struct packed {
        logic [2:0]         phase;
        row_kind_t          kind;
        logic [DEPTH_W-1:0] depth;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic [POINT_W-1:0] z;
    } dir_row_t;

    localparam calib_t DEFAULT_CAL =
        '{CENTER_X_RST, CENTER_Y_RST, INV_FX_RST, INV_FY_RST, INV_DEPTH_RST};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    calib_t  active_cal = DEFAULT_CAL;
    point_t  expected_points [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      idle_enabled = 1'b1;

    // Calibration for each directed phase; phase 0 is the reset setting
    calib_t directed_cal [0:DIR_PHASES-1] = '{
        DEFAULT_CAL,
        '{16'h0000, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF},
        '{16'h1234, 16'hABCD, 24'h000000, 24'h000000, 32'h0001_0000},
        '{16'hFFFF, 16'h0000, 24'h000001, 24'h000001, 32'h0000_0001},
        '{16'h8000, 16'h8000, 24'h800000, 24'h800000, 32'h0001_0000}
    };

    // Directed pixels: phase, kind, depth, column, line, blue, green, red, x, y, z
    dir_row_t directed_rows [0:DIR_ROWS-1] = '{
        // reset calibration: no-depth pixels, extremes, near center
        '{3'd0, ROW_NO_POINT, 16'd0,     12'd100,  12'd100,  8'h12, 8'h34, 8'h56, 32'h0, 32'h0, 32'h0},
        '{3'd0, ROW_PREDICT,  16'd5000,  12'd320,  12'd240,  8'h11, 8'h22, 8'h33, 32'h0, 32'h0, 32'h0},
        '{3'd0, ROW_PREDICT,  16'hFFFF,  12'hFFF,  12'hFFF,  8'hFF, 8'hFF, 8'hFF, 32'h0, 32'h0, 32'h0},
        '{3'd0, ROW_PREDICT,  16'd1,     12'd0,    12'd0,    8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0},
        '{3'd0, ROW_NO_POINT, 16'd0,     12'hFFF,  12'hFFF,  8'hFF, 8'hFF, 8'hFF, 32'h0, 32'h0, 32'h0},
        '{3'd0, ROW_PREDICT,  16'd1000,  12'd319,  12'd239,  8'h80, 8'h40, 8'h20, 32'h0, 32'h0, 32'h0},
        // largest scales: lateral saturation both ways, largest z
        '{3'd1, ROW_LITERAL,  16'hFFFF,  12'hFFF,  12'd0,    8'hA5, 8'h5A, 8'hC3,
          32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_FFFF},
        '{3'd1, ROW_LITERAL,  16'hFFFF,  12'd0,    12'hFFF,  8'h3C, 8'hC3, 8'h3C,
          32'h0000_0000, 32'h8000_0000, 32'hFFFE_FFFF},
        '{3'd1, ROW_PREDICT,  16'd1,     12'd1,    12'hFFF,  8'h01, 8'h02, 8'h04, 32'h0, 32'h0, 32'h0},
        '{3'd1, ROW_NO_POINT, 16'd0,     12'd0,    12'd0,    8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0},
        // zero focal reciprocals and unit depth scale: x = y = 0, z = depth
        '{3'd2, ROW_LITERAL,  16'd1,     12'hFFF,  12'd0,    8'h10, 8'h20, 8'h30, 32'h0, 32'h0, 32'h1},
        '{3'd2, ROW_LITERAL,  16'hFFFF,  12'd0,    12'hFFF,  8'h40, 8'h50, 8'h60,
          32'h0, 32'h0, 32'h0000_FFFF},
        '{3'd2, ROW_LITERAL,  16'h8000,  12'h800,  12'h800,  8'h70, 8'h80, 8'h90,
          32'h0, 32'h0, 32'h0000_8000},
        // smallest scales: z rounds to zero or one
        '{3'd3, ROW_LITERAL,  16'h7FFF,  12'd0,    12'd0,    8'hDE, 8'hAD, 8'hBE, 32'h0, 32'h0, 32'h0},
        '{3'd3, ROW_LITERAL,  16'h8000,  12'd0,    12'hFFF,  8'hEF, 8'h01, 8'h23, 32'h0, 32'h0, 32'h1},
        '{3'd3, ROW_PREDICT,  16'hFFFF,  12'hFFF,  12'hFFF,  8'h45, 8'h67, 8'h89, 32'h0, 32'h0, 32'h0},
        '{3'd3, ROW_NO_POINT, 16'd0,     12'h7FF,  12'h7FF,  8'hAB, 8'hCD, 8'hEF, 32'h0, 32'h0, 32'h0},
        // half-way ties round away from zero on both sides of the center
        '{3'd4, ROW_LITERAL,  16'd1,     12'h801,  12'h7FF,  8'h5A, 8'hA5, 8'h5A,
          32'h0000_0001, 32'hFFFF_FFFF, 32'h1},
        '{3'd4, ROW_LITERAL,  16'd1,     12'h800,  12'h800,  8'h0F, 8'hF0, 8'h0F, 32'h0, 32'h0, 32'h1},
        '{3'd4, ROW_PREDICT,  16'hAAAA,  12'h555,  12'hAAA,  8'h55, 8'hAA, 8'h55, 32'h0, 32'h0, 32'h0},
        '{3'd4, ROW_PREDICT,  16'h5555,  12'hAAA,  12'h555,  8'hAA, 8'h55, 8'hAA, 32'h0, 32'h0, 32'h0},
        '{3'd4, ROW_PREDICT,  16'd3,     12'h7FF,  12'h801,  8'h99, 8'h66, 8'h33, 32'h0, 32'h0, 32'h0}
    };

    depth_pixel_unprojection DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // Depth in Q16.16 meters, round half up, saturated
    function automatic logic [POINT_W-1:0] depth_to_meters(input logic [DEPTH_W-1:0] depth,
                                                           input logic [INV_D_W-1:0] inv_depth);
        logic [63:0]        scaled;
        logic [POINT_W-1:0] meters;
        scaled = ({48'd0, depth} * {32'd0, inv_depth} + 64'h8000) >> Z_SHIFT;
        meters = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[POINT_W-1:0];
        return meters;
    endfunction

    // Lateral offset in Q16.16 meters, round half away from zero, saturated
    function automatic logic [POINT_W-1:0] offset_to_meters(input logic [COORD_W-1:0] coord,
                                                            input logic [CENTER_W-1:0] center,
                                                            input logic [POINT_W-1:0] z,
                                                            input logic [INV_F_W-1:0] inv);
        logic [19:0]        pos;
        logic [19:0]        mag;
        logic               below;
        logic [79:0]        prod;
        logic [79:0]        rounded;
        logic [POINT_W-1:0] meters;
        pos     = 20'(coord[COORD_BITS-1:0]) << 4;
        below   = pos < {4'd0, center};
        mag     = below ? {4'd0, center} - pos : pos - {4'd0, center};
        prod    = {60'd0, mag} * {48'd0, z} * {56'd0, inv};
        rounded = (prod + (80'd1 << (LAT_SHIFT - 1))) >> LAT_SHIFT;
        if (below)
            meters = (rounded >= 80'h8000_0000) ? 32'h8000_0000 : 32'd0 - rounded[31:0];
        else
            meters = (rounded > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : rounded[31:0];
        return meters;
    endfunction

    // Point that a pixel with nonzero depth maps to under the active calibration
    function automatic point_t project_pixel(input pixel_t px);
        point_t pt;
        pt.z     = depth_to_meters(px.depth, active_cal.inv_depth);
        pt.x     = offset_to_meters(px.column, active_cal.center_x, pt.z, active_cal.inv_fx);
        pt.y     = offset_to_meters(px.line, active_cal.center_y, pt.z, active_cal.inv_fy);
        pt.blue  = px.blue;
        pt.green = px.green;
        pt.red   = px.red;
        return pt;
    endfunction

    function automatic calib_t random_calibration();
        calib_t cal;
        case ($urandom_range(0, 3))
            0: cal = DEFAULT_CAL;
            1:
            begin
                cal.center_x  = 16'($urandom);
                cal.center_y  = 16'($urandom);
                cal.inv_fx    = 24'($urandom_range(1, 24'hFFFFFF));
                cal.inv_fy    = 24'($urandom_range(1, 24'hFFFFFF));
                cal.inv_depth = $urandom_range(1, 32'hFFFF_FFFF);
            end
            2:
            begin
                cal.center_x  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                cal.center_y  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                cal.inv_fx    = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000001;
                cal.inv_fy    = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000001;
                cal.inv_depth = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            end
            default:
            begin
                // camera-like: focal 128..4096 px, 500..20000 depth units per meter
                cal.center_x  = 16'($urandom_range(0, 16'hFFF0));
                cal.center_y  = 16'($urandom_range(0, 16'hFFF0));
                cal.inv_fx    = 24'($urandom_range(24'h001000, 24'h020000));
                cal.inv_fy    = 24'($urandom_range(24'h001000, 24'h020000));
                cal.inv_depth = $urandom_range(32'd214748, 32'd8589934);
            end
        endcase
        return cal;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        case ($urandom_range(0, 9))
            0: px.depth = '0;
            1: px.depth = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
            default: px.depth = 16'($urandom);
        endcase
        if ($urandom_range(0, 9) == 0)
            px.column = $urandom_range(0, 1) ? 12'hFFF : 12'd0;
        else
            px.column = 12'($urandom);
        if ($urandom_range(0, 9) == 0)
            px.line = $urandom_range(0, 1) ? 12'hFFF : 12'd0;
        else
            px.line = 12'($urandom);
        px.blue  = 8'($urandom);
        px.green = 8'($urandom);
        px.red   = 8'($urandom);
        return px;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
            report_mismatch($sformatf("%s expected %h got %h", name, exp_val, act_val));
    endtask

    // Write one register, then read it back when it is mapped
    task automatic program_register(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] kept;
        logic              mapped;
        mapped = 1'b1;
        kept   = '0;
        case (idx)
            REG_CENTER_X:  kept = {16'd0, value[CENTER_W-1:0]};
            REG_CENTER_Y:  kept = {16'd0, value[CENTER_W-1:0]};
            REG_INV_FX:    kept = {8'd0, value[INV_F_W-1:0]};
            REG_INV_FY:    kept = {8'd0, value[INV_F_W-1:0]};
            REG_INV_DEPTH: kept = value;
            default:       mapped = 1'b0;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_CENTER_X:  active_cal.center_x  = kept[CENTER_W-1:0];
            REG_CENTER_Y:  active_cal.center_y  = kept[CENTER_W-1:0];
            REG_INV_FX:    active_cal.inv_fx    = kept[INV_F_W-1:0];
            REG_INV_FY:    active_cal.inv_fy    = kept[INV_F_W-1:0];
            REG_INV_DEPTH: active_cal.inv_depth = kept;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (mapped)
        begin
            // read back through a fresh setup and access cycle
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            check_field($sformatf("register %0d readback", idx), kept, prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        else
            psel <= 1'b0;
        // idle the bus before the next transfer
        @(posedge clk);
    endtask

    // Program all registers, with junk above each narrower register, then write an unmapped address
    task automatic load_calibration(input calib_t cal);
        program_register(REG_CENTER_X, {16'($urandom), cal.center_x});
        program_register(REG_CENTER_Y, {16'($urandom), cal.center_y});
        program_register(REG_INV_FX, {8'($urandom), cal.inv_fx});
        program_register(REG_INV_FY, {8'($urandom), cal.inv_fy});
        program_register(REG_INV_DEPTH, cal.inv_depth);
        program_register(REG_UNMAPPED, $urandom);
    endtask

    // Drop valid, wait for every point, then let the pipe drain with valid low
    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(input pixel_t px, input row_kind_t kind, input point_t lit);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // record the point this request must produce, if any
        case (kind)
            ROW_LITERAL:  expected_points.insert(expected_points.size(), lit);
            ROW_NO_POINT: ;
            default:
                if (px.depth != '0)
                    expected_points.insert(expected_points.size(), project_pixel(px));
        endcase
    endtask

    // Compare each accepted point with the oldest expectation
    always @(posedge clk)
    begin : point_check
        point_t got;
        point_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_points.size() == 0)
                report_mismatch($sformatf("unexpected point x=%h y=%h z=%h", got.x, got.y,
                                          got.z));
            else
            begin
                want = expected_points.pop_front();
                check_field("point_x", want.x, got.x);
                check_field("point_y", want.y, got.y);
                check_field("point_z", want.z, got.z);
                check_field("blue_out", {24'd0, want.blue}, {24'd0, got.blue});
                check_field("green_out", {24'd0, want.green}, {24'd0, got.green});
                check_field("red_out", {24'd0, want.red}, {24'd0, got.red});
            end
        end
    end

    // Count cycles with no request moving on any port
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stall the output side in short random bursts
    initial
    begin : sink_stall
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_enabled && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        pixel_t   px;
        point_t   lit;
        int       cur_phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels, reprogramming at each phase boundary
        cur_phase = 0;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = directed_rows[i];
            if (int'(row.phase) != cur_phase)
            begin
                settle_pipeline();
                cur_phase = int'(row.phase);
                load_calibration(directed_cal[cur_phase]);
            end
            px.depth  = row.depth;
            px.column = row.column;
            px.line   = row.line;
            px.blue   = row.blue;
            px.green  = row.green;
            px.red    = row.red;
            lit.x     = row.x;
            lit.y     = row.y;
            lit.z     = row.z;
            lit.blue  = row.blue;
            lit.green = row.green;
            lit.red   = row.red;
            send_pixel(px, row.kind, lit);
        end

        // random pixels, the reset calibration first and then a random one per phase; the last runs flat out
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            settle_pipeline();
            load_calibration((p == 0) ? DEFAULT_CAL : random_calibration());
            idle_enabled = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                send_pixel(random_pixel(), ROW_PREDICT, '0);
        end

        settle_pipeline();
        if (mismatches == 0 && expected_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### depth_pixel_unprojection.f
sv/dpu_pkg.sv
sv/depth_pixel_unprojection.sv
verif/depth_pixel_unprojection_tb.sv
